[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker module of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds at every edge outside reset.
`define CHK_ALWAYS(lbl, c) lbl: assert property (@(posedge clk) disable iff (!rst_n) (c)) \
  else $error("assertion failed");

// Same-cycle implication.
`define CHK_IMPLY(lbl, a, b) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
  (a) |-> (b)) else $error("assertion failed");

// Next-cycle implication.
`define CHK_NEXT(lbl, a, b) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
  (a) |=> (b)) else $error("assertion failed");

`endif

[rtl/pld_pkg.sv]
// ----------------------------------------------------------------------------
// pld_pkg
// Widths and stage records of the point-to-line distance pipeline.
// ----------------------------------------------------------------------------
package pld_pkg;

  localparam int CRD_W  = 16;            // coordinate width
  localparam int DIF_W  = CRD_W + 1;     // coordinate difference
  localparam int PRD_W  = 2 * DIF_W;     // product of two differences
  localparam int MAG_W  = PRD_W;         // magnitude of a cross term / squared length
  localparam int HLF_W  = MAG_W / 2;     // half of a magnitude
  localparam int SQ_W   = 2 * MAG_W;     // squared cross term
  localparam int OUT_W  = 17;            // result width
  localparam int IN_W   = 9 * CRD_W;
  localparam int ODAT_W = ((2 * OUT_W + 7) / 8) * 8;
  localparam int FRONT_LAT = 6;
  localparam int DIV_LAT   = MAG_W;      // one quotient bit per cell
  localparam int SQRT_LAT  = OUT_W;      // one root bit per cell

  typedef struct packed {
    logic [SQ_W-1:0]  s;     // squared cross product
    logic [MAG_W-1:0] lsq;   // squared length
    logic             degen;
  } front_t;

  typedef struct packed {
    logic [MAG_W-1:0] rem;
    logic [MAG_W-1:0] num;
    logic [MAG_W-1:0] quot;
    logic [MAG_W-1:0] lsq;
    logic             degen;
  } div_t;

  typedef struct packed {
    logic [OUT_W:0]   rem;
    logic [OUT_W-1:0] root;
    logic [MAG_W-1:0] rad;
  } sqrt_t;

endpackage

[rtl/pld_front.sv]
// ----------------------------------------------------------------------------
// pld_front
// Differences, cross product, squared length and squared cross product.
// ----------------------------------------------------------------------------
module pld_front (
  input  logic                         clk,
  input  logic                         en,
  input  logic [pld_pkg::IN_W-1:0]     pts,
  output pld_pkg::front_t              res
);

  localparam int DW = pld_pkg::DIF_W;
  localparam int PW = pld_pkg::PRD_W;
  localparam int MW = pld_pkg::MAG_W;
  localparam int HW = pld_pkg::HLF_W;
  localparam int SW = pld_pkg::SQ_W;
  localparam int CW = pld_pkg::CRD_W;

  logic signed [DW-1:0]  u_r [3];
  logic signed [DW-1:0]  v_r [3];
  logic signed [PW-1:0]  sq_r [3];
  logic signed [PW-1:0]  cr_r [6];
  logic [MW-1:0]         lsq3_r, lsq4_r, lsq5_r, lsq6_r;
  logic                  dg4_r, dg5_r, dg6_r;
  logic [MW-1:0]         mag_r [3];
  logic [MW-1:0]         hh_r [3];
  logic [MW-1:0]         hl_r [3];
  logic [MW-1:0]         ll_r [3];
  logic [SW-1:0]         tsq_r [3];
  logic [SW-1:0]         s_r;
  logic signed [PW:0]    dif [3];
  logic signed [DW-1:0]  pa [3];
  logic signed [DW-1:0]  pb [3];
  logic signed [DW-1:0]  pc [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pa[i] = DW'($signed(pts[i*CW +: CW]));
      pb[i] = DW'($signed(pts[(i+3)*CW +: CW]));
      pc[i] = DW'($signed(pts[(i+6)*CW +: CW]));
    end
    // i = uy*vz - uz*vy, j = uz*vx - ux*vz, k = ux*vy - uy*vx
    for (int i = 0; i < 3; i++) begin
      dif[i] = (PW+1)'(cr_r[2*i]) - (PW+1)'(cr_r[2*i+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        u_r[i]  <= pb[i] - pa[i];
        v_r[i]  <= pc[i] - pa[i];
        sq_r[i] <= PW'(u_r[i]) * PW'(u_r[i]);
      end
      cr_r[0] <= PW'(u_r[1]) * PW'(v_r[2]);
      cr_r[1] <= PW'(u_r[2]) * PW'(v_r[1]);
      cr_r[2] <= PW'(u_r[2]) * PW'(v_r[0]);
      cr_r[3] <= PW'(u_r[0]) * PW'(v_r[2]);
      cr_r[4] <= PW'(u_r[0]) * PW'(v_r[1]);
      cr_r[5] <= PW'(u_r[1]) * PW'(v_r[0]);
      lsq3_r <= MW'(sq_r[0]) + MW'(sq_r[1]) + MW'(sq_r[2]);
      for (int i = 0; i < 3; i++) begin
        mag_r[i] <= dif[i][PW] ? MW'(-dif[i]) : MW'(dif[i]);
        hh_r[i]  <= MW'(mag_r[i][MW-1:HW]) * MW'(mag_r[i][MW-1:HW]);
        hl_r[i]  <= MW'(mag_r[i][MW-1:HW]) * MW'(mag_r[i][HW-1:0]);
        ll_r[i]  <= MW'(mag_r[i][HW-1:0]) * MW'(mag_r[i][HW-1:0]);
        tsq_r[i] <= {hh_r[i], {MW{1'b0}}} + (SW'(hl_r[i]) << (HW + 1)) + SW'(ll_r[i]);
      end
      lsq4_r <= lsq3_r;
      dg4_r  <= (lsq3_r == '0);
      lsq5_r <= lsq4_r;
      dg5_r  <= dg4_r;
      lsq6_r <= lsq5_r;
      dg6_r  <= dg5_r;
      s_r    <= tsq_r[0] + tsq_r[1] + tsq_r[2];
    end
  end

  assign res.s     = s_r;
  assign res.lsq   = lsq6_r;
  assign res.degen = dg6_r;

endmodule

[rtl/pld_div_cell.sv]
// ----------------------------------------------------------------------------
// pld_div_cell
// One restoring division step: one quotient bit per cell.
// ----------------------------------------------------------------------------
module pld_div_cell (
  input  logic            clk,
  input  logic            en,
  input  pld_pkg::div_t   d_in,
  output pld_pkg::div_t   d_out
);

  localparam int MW = pld_pkg::MAG_W;

  pld_pkg::div_t d_r;
  logic [MW:0]   rr;
  logic          ge;

  always_comb begin
    rr = {d_in.rem, d_in.num[MW-1]};
    ge = (rr >= {1'b0, d_in.lsq});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r.rem   <= ge ? MW'(rr - {1'b0, d_in.lsq}) : rr[MW-1:0];
      d_r.num   <= {d_in.num[MW-2:0], 1'b0};
      d_r.quot  <= {d_in.quot[MW-2:0], ge};
      d_r.lsq   <= d_in.lsq;
      d_r.degen <= d_in.degen;
    end
  end

  assign d_out = d_r;

endmodule

[rtl/pld_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// pld_sqrt_cell
// One digit-by-digit square root step: one root bit per cell.
// ----------------------------------------------------------------------------
module pld_sqrt_cell (
  input  logic            clk,
  input  logic            en,
  input  pld_pkg::sqrt_t  q_in,
  output pld_pkg::sqrt_t  q_out
);

  localparam int OW = pld_pkg::OUT_W;
  localparam int MW = pld_pkg::MAG_W;

  pld_pkg::sqrt_t q_r;
  logic [OW+2:0]  t;
  logic [OW+2:0]  d;
  logic           ge;

  always_comb begin
    t  = {q_in.rem, q_in.rad[MW-1:MW-2]};
    d  = {1'b0, q_in.root, 2'b01};
    ge = (t >= d);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r.rem  <= ge ? (OW+1)'(t - d) : t[OW:0];
      q_r.root <= {q_in.root[OW-2:0], ge};
      q_r.rad  <= {q_in.rad[MW-3:0], 2'b00};
    end
  end

  assign q_out = q_r;

endmodule

[rtl/point_line_distance_3d.sv]
// ----------------------------------------------------------------------------
// point_line_distance_3d
// Distance of a point from the line through two points, fully pipelined.
// ----------------------------------------------------------------------------
// The block takes one request per cycle unless the output stalls, and returns
// one result per request, in order. A request carries points A, B and C in
// signed Q8.8; the result gives |AB x AC| / |AB| and |AB|, both unsigned Q.8
// truncated, and flags A equal to B, in which case the distance reads zero.
// The chain is six stages of differences, products and sums, then 34
// division cells that each produce one quotient bit of |AB x AC|^2 / |AB|^2,
// then 17 pairs of square root cells that each produce one bit of both
// roots, and the output register. The whole chain advances together; it
// stalls only while a result waits in the output register and the sink
// holds out_tready low.
module point_line_distance_3d (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z (16 bits each)
  input  logic [pld_pkg::IN_W-1:0]    in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // line_distance [16:0], segment_length [33:17], zero fill
  output logic [pld_pkg::ODAT_W-1:0]  out_tdata,
  // degenerate
  output logic                        out_tuser
);

  localparam int OW  = pld_pkg::OUT_W;
  localparam int MW  = pld_pkg::MAG_W;
  localparam int LAT = pld_pkg::FRONT_LAT + pld_pkg::DIV_LAT + pld_pkg::SQRT_LAT + 1;

  logic                          en;
  logic [LAT-1:0]                vld_r, vld_nxt;
  pld_pkg::front_t               fr;
  pld_pkg::div_t                 dv [pld_pkg::DIV_LAT+1];
  pld_pkg::sqrt_t                qd [pld_pkg::SQRT_LAT+1];
  pld_pkg::sqrt_t                ql [pld_pkg::SQRT_LAT+1];
  logic [pld_pkg::SQRT_LAT-1:0]  dg_r;
  logic [OW-1:0]                 dist_r, len_r;
  logic                          degen_r;

  // Everything moves when the output register is free or being emptied.
  assign en        = !vld_r[LAT-1] || out_tready;
  assign in_tready = en;

  always_comb begin
    vld_nxt = {vld_r[LAT-2:0], in_tvalid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  pld_front u_front (.clk(clk), .en(en), .pts(in_tdata), .res(fr));

  // Remainder starts from the upper half of the dividend; it is below the
  // divisor because the quotient never needs more than MAG_W bits.
  assign dv[0].rem   = fr.s[2*MW-1:MW];
  assign dv[0].num   = fr.s[MW-1:0];
  assign dv[0].quot  = '0;
  assign dv[0].lsq   = fr.lsq;
  assign dv[0].degen = fr.degen;

  for (genvar g = 0; g < pld_pkg::DIV_LAT; g++) begin : g_div
    pld_div_cell u_cell (.clk(clk), .en(en), .d_in(dv[g]), .d_out(dv[g+1]));
  end

  assign qd[0].rem  = '0;
  assign qd[0].root = '0;
  assign qd[0].rad  = dv[pld_pkg::DIV_LAT].quot;
  assign ql[0].rem  = '0;
  assign ql[0].root = '0;
  assign ql[0].rad  = dv[pld_pkg::DIV_LAT].lsq;

  // Two root lanes side by side: the distance and the segment length.
  for (genvar g = 0; g < pld_pkg::SQRT_LAT; g++) begin : g_sqrt
    pld_sqrt_cell u_dist (.clk(clk), .en(en), .q_in(qd[g]), .q_out(qd[g+1]));
    pld_sqrt_cell u_len  (.clk(clk), .en(en), .q_in(ql[g]), .q_out(ql[g+1]));
  end

  // The degenerate flag travels beside the root lanes.
  always_ff @(posedge clk) begin
    if (en) begin
      dg_r <= {dg_r[pld_pkg::SQRT_LAT-2:0], dv[pld_pkg::DIV_LAT].degen};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dist_r  <= dg_r[pld_pkg::SQRT_LAT-1] ? '0 : qd[pld_pkg::SQRT_LAT].root;
      len_r   <= ql[pld_pkg::SQRT_LAT].root;
      degen_r <= dg_r[pld_pkg::SQRT_LAT-1];
    end
  end

  assign out_tvalid = vld_r[LAT-1];
  assign out_tdata  = {{(pld_pkg::ODAT_W - 2*OW){1'b0}}, len_r, dist_r};
  assign out_tuser  = degen_r;

endmodule

[rtl/pld_checker.sv]
// ----------------------------------------------------------------------------
// pld_checker
// Port-level checks of the point-to-line distance block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pld_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic [pld_pkg::ODAT_W-1:0]  out_tdata,
  input  logic                        out_tuser
);

  localparam int OW = pld_pkg::OUT_W;

  // A stalled result stays offered and unchanged.
  `CHK_NEXT(a_hold_vld, out_tvalid && !out_tready, out_tvalid)
  `CHK_NEXT(a_hold_dat, out_tvalid && !out_tready, $stable(out_tdata) && $stable(out_tuser))
  // A degenerate line reports zero distance and zero length.
  `CHK_IMPLY(a_degen_zero, out_tvalid && out_tuser, out_tdata[2*OW-1:0] == '0)
  // A non-degenerate line has a nonzero length.
  `CHK_IMPLY(a_len_nz, out_tvalid && !out_tuser, out_tdata[2*OW-1:OW] != '0)

endmodule

bind point_line_distance_3d pld_checker u_pld_checker (.*);

[tb/sv/point_line_distance_3d_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// point_line_distance_3d_test
// Self-checking bench for the point-to-line distance pipeline.
// ----------------------------------------------------------------------------
// Directed corner requests, then random ones, go through a queue to a driver
// with random gaps. A monitor with random stalls checks each result against
// a predictor that computes the squared cross product and squared length
// exactly and takes truncated integer roots and the quotient.
// ----------------------------------------------------------------------------
module point_line_distance_3d_test;

  localparam int CRD_W  = pld_pkg::CRD_W;
  localparam int PRD_W  = pld_pkg::PRD_W;
  localparam int OUT_W  = pld_pkg::OUT_W;
  localparam int IN_W   = pld_pkg::IN_W;
  localparam int ODAT_W = pld_pkg::ODAT_W;
  localparam int CROSS_W = 2 * PRD_W + 2;
  localparam int SUMSQ_W = 2 * CROSS_W + 2;
  localparam int WATCHDOG = 20000;

  typedef logic signed [CRD_W-1:0] coord_t;

  typedef struct packed {
    logic [OUT_W-1:0] dst;
    logic [OUT_W-1:0] len;
    logic             degen;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [ODAT_W-1:0] out_tdata;
  logic out_tuser;

  logic [IN_W-1:0] pending_requests[$];
  answer_t expected_answers[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int send_gap = 0;
  int sink_gap = 0;
  int hold_off = 0;
  bit feeding_done = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  point_line_distance_3d i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // Integer floor square root by bit-wise trial.
  function automatic logic [SUMSQ_W-1:0] isqrt(input logic [SUMSQ_W-1:0] x);
    logic [SUMSQ_W-1:0] r;
    logic [SUMSQ_W-1:0] t;
    r = '0;
    for (int b = SUMSQ_W / 2 - 1; b >= 0; b--) begin
      t = r | (SUMSQ_W'(1) << b);
      if (t * t <= x) r = t;
    end
    return r;
  endfunction

  function automatic logic [OUT_W-1:0] clamp(input logic [SUMSQ_W-1:0] v);
    return (v > SUMSQ_W'(131071)) ? 17'h1ffff : v[OUT_W-1:0];
  endfunction

  // Expected distance, length and degenerate flag for one request.
  function automatic answer_t distance_of(input logic [IN_W-1:0] req);
    coord_t p[9];
    logic signed [CROSS_W-1:0] u[3];
    logic signed [CROSS_W-1:0] v[3];
    logic signed [CROSS_W-1:0] cr[3];
    logic [SUMSQ_W-1:0] lsq;
    logic [SUMSQ_W-1:0] s;
    answer_t a;
    for (int i = 0; i < 9; i++) p[i] = req[i*CRD_W +: CRD_W];
    for (int i = 0; i < 3; i++) begin
      u[i] = CROSS_W'(p[3+i]) - CROSS_W'(p[i]);
      v[i] = CROSS_W'(p[6+i]) - CROSS_W'(p[i]);
    end
    cr[0] = u[1] * v[2] - u[2] * v[1];
    cr[1] = u[2] * v[0] - u[0] * v[2];
    cr[2] = u[0] * v[1] - u[1] * v[0];
    lsq = '0;
    s = '0;
    for (int i = 0; i < 3; i++) begin
      lsq += SUMSQ_W'(u[i] * u[i]);
      s += SUMSQ_W'(cr[i]) * SUMSQ_W'(cr[i]);
    end
    if (lsq == '0) begin
      a = '{dst: '0, len: '0, degen: 1'b1};
    end else begin
      a.dst = clamp(isqrt(s / lsq));
      a.len = clamp(isqrt(lsq));
      a.degen = 1'b0;
    end
    return a;
  endfunction

  function automatic logic [IN_W-1:0] pack_points(input coord_t c[9]);
    logic [IN_W-1:0] r;
    for (int i = 0; i < 9; i++) r[i*CRD_W +: CRD_W] = c[i];
    return r;
  endfunction

  function automatic coord_t rand_coord(input int span);
    if (span == 0) return coord_t'($urandom);
    return coord_t'($urandom_range(0, 2 * span) - span);
  endfunction

  // Driver: offers the oldest pending request after a random gap.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        send_gap <= $urandom_range(0, 9);
        if (send_gap == 0 && pending_requests.size() > 1) begin
          expected_answers = {expected_answers, distance_of(pending_requests[0])};
          void'(pending_requests.pop_front());
          in_tdata <= pending_requests[0];
        end else begin
          expected_answers = {expected_answers, distance_of(pending_requests.pop_front())};
          in_tvalid <= 1'b0;
        end
      end else if (!in_tvalid) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
        end else if (pending_requests.size() > 0) begin
          in_tvalid <= 1'b1;
          in_tdata <= pending_requests[0];
        end
      end
    end
  end

  // Monitor: random stalls, plus one long hold-off so the pipeline backs up.
  always @(posedge clk) begin
    answer_t got;
    answer_t exp_a;
    int gap;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = '{dst: out_tdata[OUT_W-1:0], len: out_tdata[2*OUT_W-1:OUT_W],
                degen: out_tuser};
        if (expected_answers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          exp_a = expected_answers.pop_front();
          if (got !== exp_a) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p, got %p", exp_a, got);
          end
        end
        gap = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 9));
        sink_gap <= gap;
        out_tready <= (gap == 0);
      end else if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_tready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap <= sink_gap - 1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any accepted request or result.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("point_line_distance_3d_test: errors");
      $finish;
    end
  end

  initial begin
    coord_t c[9];
    int span;
    // Directed: degenerate lines, extremes, collinear C, C on A.
    c = '{default: coord_t'(0)};
    pending_requests = {pending_requests, pack_points(c)};
    c = '{default: coord_t'(16'h8000)};
    pending_requests = {pending_requests, pack_points(c)};
    c = '{default: coord_t'(16'h7fff)};
    pending_requests = {pending_requests, pack_points(c)};
    c = '{16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff,
          16'h8000, 16'h7fff, 16'h8000};
    pending_requests = {pending_requests, pack_points(c)};
    c = '{16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
          16'h7fff, 16'h7fff, 16'h8000};
    pending_requests = {pending_requests, pack_points(c)};
    c = '{16'h8000, 16'h0, 16'h0, 16'h7fff, 16'h0, 16'h0, 16'h0, 16'h7fff, 16'h7fff};
    pending_requests = {pending_requests, pack_points(c)};
    c = '{16'h0, 16'h0, 16'h0, 16'h0001, 16'h0, 16'h0, 16'h0, 16'h7fff, 16'h8000};
    pending_requests = {pending_requests, pack_points(c)};
    c = '{16'h0, 16'h0, 16'h0, 16'h0100, 16'h0100, 16'h0100,
          16'h0300, 16'h0300, 16'h0300};
    pending_requests = {pending_requests, pack_points(c)};
    c = '{16'h1234, 16'hfedc, 16'h0042, 16'h0, 16'h0, 16'h0,
          16'h1234, 16'hfedc, 16'h0042};
    pending_requests = {pending_requests, pack_points(c)};
    c = '{16'h1234, 16'hfedc, 16'h0042, 16'h1234, 16'hfedc, 16'h0042,
          16'h5555, 16'haaaa, 16'hffff};
    pending_requests = {pending_requests, pack_points(c)};
    c = '{16'hffff, 16'hffff, 16'hffff, 16'h0, 16'h0, 16'h0, 16'h8000, 16'h0, 16'h7fff};
    pending_requests = {pending_requests, pack_points(c)};
    // Random: full range, small coordinates, and some with A equal to B or C equal to A.
    for (int n = 0; n < 1000; n++) begin
      case ($urandom_range(0, 3))
        0: span = 0;
        1: span = 300;
        2: span = 4000;
        default: span = 32767;
      endcase
      for (int i = 0; i < 9; i++) c[i] = rand_coord(span);
      if ($urandom_range(0, 15) == 0) for (int i = 0; i < 3; i++) c[3+i] = c[i];
      if ($urandom_range(0, 15) == 0) for (int i = 0; i < 3; i++) c[6+i] = c[i];
      pending_requests = {pending_requests, pack_points(c)};
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    hold_off <= 400;
    wait (pending_requests.size() == 0 && !in_tvalid);
    wait (expected_answers.size() == 0);
    repeat (80) @(posedge clk);
    if (mismatches == 0 && expected_answers.size() == 0) begin
      $display("point_line_distance_3d_test: clean");
    end else begin
      $display("point_line_distance_3d_test: errors");
    end
    $finish;
  end

endmodule
